/* rtl/hcbs_pkg.sv */
`timescale 1ns / 1ps

package hcbs_pkg;

   localparam int NODE_W = 8;
   localparam int PAY_W  = 20;
   localparam int SUB_W  = 5;

   // input commands
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_REPLY = 1'b1;

   // verb payloads
   localparam logic [PAY_W-1:0] VB_GET_NODE_CNT  = 20'hF0004;
   localparam logic [PAY_W-1:0] VB_GET_FG_TYPE   = 20'hF0005;
   localparam logic [PAY_W-1:0] VB_POWER_D0      = 20'h70500;
   localparam logic [PAY_W-1:0] VB_GET_WCAP      = 20'hF0009;
   localparam logic [PAY_W-1:0] VB_STREAM_FMT    = 20'h24011;
   localparam logic [PAY_W-1:0] VB_STREAM_CH     = 20'h70610;
   localparam logic [PAY_W-1:0] VB_AMP_OUT_UNMUTE = 20'h3B077;
   localparam logic [PAY_W-1:0] VB_AMP_ALL_UNMUTE = 20'h3B777;
   localparam logic [PAY_W-1:0] VB_GET_PIN_CFG   = 20'hF1C00;
   localparam logic [PAY_W-1:0] VB_CONN_SEL0     = 20'h70100;
   localparam logic [PAY_W-1:0] VB_PIN_CTL       = 20'h70700;
   localparam logic [PAY_W-1:0] VB_EAPD          = 20'h70C02;
   localparam logic [PAY_W-1:0] VB_AMP_IN_UNMUTE = 20'h39077;
   localparam logic [PAY_W-1:0] VB_GET_AMP_IN    = 20'hF0012;
   localparam logic [PAY_W-1:0] VB_MIX_UNMUTE    = 20'h3A077;

   localparam logic [PAY_W-1:0] PIN_OUT_EN  = 20'h00040;
   localparam logic [PAY_W-1:0] PIN_HP_EN   = 20'h00080;

   // widget types from the capability reply
   localparam logic [3:0] WT_DAC      = 4'd0;
   localparam logic [3:0] WT_MIXER    = 4'd2;
   localparam logic [3:0] WT_SELECTOR = 4'd3;
   localparam logic [3:0] WT_PIN      = 4'd4;

   localparam logic [3:0] DEV_HEADPHONE = 4'd2;
   localparam logic [1:0] PORT_NONE     = 2'd1;

   typedef struct packed {
      logic        cmd;
      logic [14:0] codec_mask;
      logic [31:0] reply_word;
   } req_item_type;

   typedef struct packed {
      logic [31:0] verb_word;
      logic        all_done;
      logic [14:0] skipped_codecs;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } rsp_push_type;

   function automatic logic [PAY_W-1:0] dac_verb(input logic [SUB_W-1:0] k);
      logic [PAY_W-1:0] v;
      case (k)
         5'd0:    v = VB_POWER_D0;
         5'd1:    v = VB_STREAM_FMT;
         5'd2:    v = VB_STREAM_CH;
         5'd3:    v = VB_AMP_OUT_UNMUTE;
         default: v = VB_AMP_ALL_UNMUTE;
      endcase
      return v;
   endfunction

   function automatic logic [PAY_W-1:0] pin_verb(input logic [SUB_W-1:0] k,
                                                 input logic hp);
      logic [PAY_W-1:0] v;
      case (k)
         5'd0:    v = VB_POWER_D0;
         5'd1:    v = VB_CONN_SEL0;
         5'd2:    v = VB_PIN_CTL | PIN_OUT_EN | (hp ? PIN_HP_EN : '0);
         5'd3:    v = VB_EAPD;
         5'd4:    v = VB_AMP_OUT_UNMUTE;
         default: v = VB_AMP_IN_UNMUTE;
      endcase
      return v;
   endfunction

   function automatic logic [PAY_W-1:0] sel_verb(input logic [SUB_W-1:0] k);
      return (k == '0) ? VB_POWER_D0 : VB_CONN_SEL0;
   endfunction

endpackage

/* rtl/hcbs_req_if.sv */
`timescale 1ns / 1ps

interface hcbs_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [14:0] codec_mask;
   logic [31:0] reply_word;

   modport source (output valid, output cmd, output codec_mask, output reply_word,
                   input ready);
   modport sink (input valid, input cmd, input codec_mask, input reply_word,
                 output ready);
endinterface

/* rtl/hcbs_rsp_if.sv */
`timescale 1ns / 1ps

interface hcbs_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] verb_word;
   logic        all_done;
   logic [14:0] skipped_codecs;

   modport source (output valid, output verb_word, output all_done,
                   output skipped_codecs, input ready);
   modport sink (input valid, input verb_word, input all_done,
                 input skipped_codecs, output ready);
endinterface

/* rtl/hda_codec_bringup_sequencer.sv */
`timescale 1ns / 1ps

// channel   dir  payload                                   handshake
// req_chan  in   cmd, codec_mask[14:0], reply_word[31:0]   valid/ready
// rsp_chan  out  verb_word[31:0], all_done, skipped_codecs valid/ready
//
// One transaction per cycle sustained while req_chan.ready stays high; each response
// passes through the input register, then decode into the response buffer.
// Synchronous reset returns the sequencer to idle; no clearing pass.
// req_chan.ready drops only while the input register holds a transaction and
// the two-entry response buffer is full; it does not depend on rsp_chan.ready.
module hda_codec_bringup_sequencer #(
   parameter int MAX_CODECS       = 15,
   parameter int MAX_MIXER_INPUTS = 8
) (
   input  logic       clock,
   input  logic       reset,
   hcbs_req_if.sink   req_chan,
   hcbs_rsp_if.source rsp_chan
);

   hcbs_pkg::req_item_type in_ff, in_in;
   logic                   in_valid_ff, in_valid_in;
   logic                   buf_full, advance, accept;
   hcbs_pkg::rsp_push_type push;

   assign advance        = in_valid_ff & ~buf_full;
   assign req_chan.ready = ~in_valid_ff | ~buf_full;
   assign accept         = req_chan.valid & req_chan.ready;

   always_comb begin
      in_in       = in_ff;
      in_valid_in = in_valid_ff & ~advance;
      if (accept) begin
         in_in.cmd        = req_chan.cmd;
         in_in.codec_mask = req_chan.codec_mask;
         in_in.reply_word = req_chan.reply_word;
         in_valid_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_ff <= in_in;
   end

   hcbs_seq_core #(
      .MAX_CODECS       (MAX_CODECS),
      .MAX_MIXER_INPUTS (MAX_MIXER_INPUTS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .item  (in_ff),
      .push  (push)
   );

   hcbs_rsp_buf u_rsp_buf (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (buf_full),
      .rsp_chan (rsp_chan)
   );

endmodule

/* rtl/hcbs_seq_core.sv */
`timescale 1ns / 1ps

module hcbs_seq_core #(
   parameter int MAX_CODECS       = 15,
   parameter int MAX_MIXER_INPUTS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  hcbs_pkg::req_item_type item,
   output hcbs_pkg::rsp_push_type push
);

   localparam int MIX_W = $clog2(MAX_MIXER_INPUTS + 1);
   localparam logic [14:0] CODEC_LIMIT = 15'((32'd1 << MAX_CODECS) - 32'd1);
   localparam logic [6:0]  MIX_MAX     = 7'(MAX_MIXER_INPUTS);

   localparam logic [3:0] PH_IDLE   = 4'd0;
   localparam logic [3:0] PH_ROOT   = 4'd1;
   localparam logic [3:0] PH_FGTYPE = 4'd2;
   localparam logic [3:0] PH_POWER  = 4'd3;
   localparam logic [3:0] PH_RANGE  = 4'd4;
   localparam logic [3:0] PH_WCAP   = 4'd5;
   localparam logic [3:0] PH_DAC    = 4'd6;
   localparam logic [3:0] PH_PINCFG = 4'd7;
   localparam logic [3:0] PH_PIN    = 4'd8;
   localparam logic [3:0] PH_MIXCAP = 4'd9;
   localparam logic [3:0] PH_MIX    = 4'd10;
   localparam logic [3:0] PH_SEL    = 4'd11;

   logic [3:0]                   phase_ff, phase_in;
   logic [14:0]                  pending_ff, pending_in;
   logic [3:0]                   codec_ff, codec_in;
   logic [7:0]                   group_ff, group_in;
   logic [5:0]                   left_ff, left_in;
   logic [7:0]                   cur_ff, cur_in;
   logic [7:0]                   last_ff, last_in;
   logic [hcbs_pkg::SUB_W-1:0]   sub_ff, sub_in;
   logic [MIX_W-1:0]             mix_ff, mix_in;
   logic                         hp_ff, hp_in;
   logic [14:0]                  skipped_ff, skipped_in;

   logic                           emit, go_node, go_codec, found;
   logic [3:0]                     pick;
   logic [7:0]                     node_sel, fld_a, fld_b;
   logic [hcbs_pkg::PAY_W-1:0]     pay_sel;
   logic [6:0]                     mix_cnt;
   logic [31:0]                    r;

   assign r = item.reply_word;

   always_comb begin
      phase_in   = phase_ff;
      pending_in = pending_ff;
      codec_in   = codec_ff;
      group_in   = group_ff;
      left_in    = left_ff;
      cur_in     = cur_ff;
      last_in    = last_ff;
      sub_in     = sub_ff;
      mix_in     = mix_ff;
      hp_in      = hp_ff;
      skipped_in = skipped_ff;
      emit       = 1'b0;
      go_node    = 1'b0;
      go_codec   = 1'b0;
      found      = 1'b0;
      pick       = '0;
      node_sel   = '0;
      pay_sel    = '0;
      fld_a      = r[23:16];
      fld_b      = r[7:0];
      mix_cnt    = r[22:16];
      push       = '0;

      if (fire) begin
         if (item.cmd == hcbs_pkg::CMD_START) begin
            phase_in   = PH_IDLE;
            pending_in = item.codec_mask & CODEC_LIMIT;
            codec_in   = '0;
            group_in   = '0;
            left_in    = '0;
            cur_in     = '0;
            last_in    = '0;
            sub_in     = '0;
            mix_in     = '0;
            hp_in      = 1'b0;
            skipped_in = '0;
            go_codec   = 1'b1;
         end else begin
            case (phase_ff)
               PH_ROOT: begin
                  if (fld_b == 8'd0 || fld_b > 8'd32) begin
                     skipped_in = skipped_ff | (15'd1 << codec_ff);
                     go_codec   = 1'b1;
                  end else begin
                     left_in  = fld_b[5:0];
                     cur_in   = fld_a;
                     phase_in = PH_FGTYPE;
                     emit     = 1'b1;
                     node_sel = fld_a;
                     pay_sel  = hcbs_pkg::VB_GET_FG_TYPE;
                  end
               end
               PH_FGTYPE: begin
                  if (fld_b == 8'd1) begin
                     if (cur_ff == 8'd0) begin
                        skipped_in = skipped_ff | (15'd1 << codec_ff);
                        go_codec   = 1'b1;
                     end else begin
                        group_in = cur_ff;
                        phase_in = PH_POWER;
                        emit     = 1'b1;
                        node_sel = cur_ff;
                        pay_sel  = hcbs_pkg::VB_POWER_D0;
                     end
                  end else begin
                     left_in = left_ff - 6'd1;
                     if (left_in == 6'd0) begin
                        skipped_in = skipped_ff | (15'd1 << codec_ff);
                        go_codec   = 1'b1;
                     end else begin
                        cur_in   = cur_ff + 8'd1;
                        emit     = 1'b1;
                        node_sel = cur_in;
                        pay_sel  = hcbs_pkg::VB_GET_FG_TYPE;
                     end
                  end
               end
               PH_POWER: begin
                  phase_in = PH_RANGE;
                  emit     = 1'b1;
                  node_sel = group_ff;
                  pay_sel  = hcbs_pkg::VB_GET_NODE_CNT;
               end
               PH_RANGE: begin
                  // bogus child range: fall back to nodes 2..11
                  if (fld_a < 8'd2 || fld_a > 8'd100 || fld_b == 8'd0 || fld_b > 8'd64) begin
                     fld_a = 8'd2;
                     fld_b = 8'd10;
                  end
                  cur_in  = fld_a;
                  last_in = fld_a + fld_b - 8'd1;
                  go_node = 1'b1;
               end
               PH_WCAP: begin
                  sub_in = '0;
                  case (r[23:20])
                     hcbs_pkg::WT_DAC: begin
                        phase_in = PH_DAC;
                        emit     = 1'b1;
                        node_sel = cur_ff;
                        pay_sel  = hcbs_pkg::dac_verb('0);
                     end
                     hcbs_pkg::WT_PIN: begin
                        phase_in = PH_PINCFG;
                        emit     = 1'b1;
                        node_sel = cur_ff;
                        pay_sel  = hcbs_pkg::VB_GET_PIN_CFG;
                     end
                     hcbs_pkg::WT_MIXER: begin
                        phase_in = PH_MIXCAP;
                        emit     = 1'b1;
                        node_sel = cur_ff;
                        pay_sel  = hcbs_pkg::VB_GET_AMP_IN;
                     end
                     hcbs_pkg::WT_SELECTOR: begin
                        phase_in = PH_SEL;
                        emit     = 1'b1;
                        node_sel = cur_ff;
                        pay_sel  = hcbs_pkg::sel_verb('0);
                     end
                     default: begin
                        cur_in  = cur_ff + 8'd1;
                        go_node = 1'b1;
                     end
                  endcase
               end
               PH_DAC: begin
                  sub_in = sub_ff + 5'd1;
                  if (sub_in < 5'd5) begin
                     emit     = 1'b1;
                     node_sel = cur_ff;
                     pay_sel  = hcbs_pkg::dac_verb(sub_in);
                  end else begin
                     cur_in  = cur_ff + 8'd1;
                     go_node = 1'b1;
                  end
               end
               PH_PINCFG: begin
                  if (r[31:30] == hcbs_pkg::PORT_NONE) begin
                     cur_in  = cur_ff + 8'd1;
                     go_node = 1'b1;
                  end else begin
                     hp_in    = (r[23:20] == hcbs_pkg::DEV_HEADPHONE);
                     phase_in = PH_PIN;
                     sub_in   = '0;
                     emit     = 1'b1;
                     node_sel = cur_ff;
                     pay_sel  = hcbs_pkg::pin_verb('0, hp_in);
                  end
               end
               PH_PIN: begin
                  sub_in = sub_ff + 5'd1;
                  if (sub_in < 5'd6) begin
                     emit     = 1'b1;
                     node_sel = cur_ff;
                     pay_sel  = hcbs_pkg::pin_verb(sub_in, hp_ff);
                  end else begin
                     cur_in  = cur_ff + 8'd1;
                     go_node = 1'b1;
                  end
               end
               PH_MIXCAP: begin
                  if (mix_cnt > MIX_MAX) begin
                     mix_cnt = MIX_MAX;
                  end
                  if (mix_cnt == 7'd0) begin
                     cur_in  = cur_ff + 8'd1;
                     go_node = 1'b1;
                  end else begin
                     mix_in   = MIX_W'(mix_cnt);
                     sub_in   = '0;
                     phase_in = PH_MIX;
                     emit     = 1'b1;
                     node_sel = cur_ff;
                     pay_sel  = hcbs_pkg::VB_MIX_UNMUTE;
                  end
               end
               PH_MIX: begin
                  sub_in = sub_ff + 5'd1;
                  if (32'(sub_in) < 32'(mix_ff)) begin
                     emit     = 1'b1;
                     node_sel = cur_ff;
                     pay_sel  = hcbs_pkg::VB_MIX_UNMUTE | {8'd0, sub_in[3:0], 8'd0};
                  end else begin
                     cur_in  = cur_ff + 8'd1;
                     go_node = 1'b1;
                  end
               end
               PH_SEL: begin
                  sub_in = sub_ff + 5'd1;
                  if (sub_in < 5'd2) begin
                     emit     = 1'b1;
                     node_sel = cur_ff;
                     pay_sel  = hcbs_pkg::sel_verb(sub_in);
                  end else begin
                     cur_in  = cur_ff + 8'd1;
                     go_node = 1'b1;
                  end
               end
               default: begin
                  // idle: replies are dropped
               end
            endcase
         end

         if (go_node) begin
            if (cur_in > last_in) begin
               go_codec = 1'b1;
            end else begin
               phase_in = PH_WCAP;
               emit     = 1'b1;
               node_sel = cur_in;
               pay_sel  = hcbs_pkg::VB_GET_WCAP;
            end
         end

         if (go_codec) begin
            // lowest pending codec address goes next
            for (int c = MAX_CODECS - 1; c >= 0; c--) begin
               if (pending_in[c]) begin
                  found = 1'b1;
                  pick  = 4'(c);
               end
            end
            if (found) begin
               pending_in = pending_in & ~(15'd1 << pick);
               codec_in   = pick;
               phase_in   = PH_ROOT;
               emit       = 1'b1;
               node_sel   = '0;
               pay_sel    = hcbs_pkg::VB_GET_NODE_CNT;
            end else begin
               phase_in                 = PH_IDLE;
               pending_in               = '0;
               push.valid               = 1'b1;
               push.item.all_done       = 1'b1;
               push.item.skipped_codecs = skipped_in;
            end
         end

         if (emit) begin
            push.valid          = 1'b1;
            push.item.verb_word = {codec_in, node_sel, pay_sel};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         pending_ff <= '0;
         codec_ff   <= '0;
         group_ff   <= '0;
         left_ff    <= '0;
         cur_ff     <= '0;
         last_ff    <= '0;
         sub_ff     <= '0;
         mix_ff     <= '0;
         hp_ff      <= 1'b0;
         skipped_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         pending_ff <= pending_in;
         codec_ff   <= codec_in;
         group_ff   <= group_in;
         left_ff    <= left_in;
         cur_ff     <= cur_in;
         last_ff    <= last_in;
         sub_ff     <= sub_in;
         mix_ff     <= mix_in;
         hp_ff      <= hp_in;
         skipped_ff <= skipped_in;
      end
   end

endmodule

/* rtl/hcbs_rsp_buf.sv */
`timescale 1ns / 1ps

// Two-entry output buffer: head register plus skid register.
module hcbs_rsp_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  hcbs_pkg::rsp_push_type push,
   output logic                   full,
   hcbs_rsp_if.source             rsp_chan
);

   hcbs_pkg::rsp_item_type head_ff, head_in, skid_ff, skid_in;
   logic                   head_valid_ff, head_valid_in, skid_valid_ff, skid_valid_in;
   logic                   pop;

   assign pop  = head_valid_ff & rsp_chan.ready;
   assign full = head_valid_ff & skid_valid_ff;

   always_comb begin
      head_in       = head_ff;
      skid_in       = skid_ff;
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop || !head_valid_ff) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            head_valid_in = 1'b1;
            skid_in       = push.item;
            skid_valid_in = push.valid;
         end else begin
            head_in       = push.item;
            head_valid_in = push.valid;
         end
      end else if (push.valid) begin
         skid_in       = push.item;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid          = head_valid_ff;
   assign rsp_chan.verb_word      = head_ff.verb_word;
   assign rsp_chan.all_done       = head_ff.all_done;
   assign rsp_chan.skipped_codecs = head_ff.skipped_codecs;

endmodule

/* tb/hcbs_seq_checker.sv */
`timescale 1ns / 1ps

module hcbs_seq_checker #(
   parameter int MAX_CODECS       = 15,
   parameter int MAX_MIXER_INPUTS = 8
) (
   input  logic clock,
   input  logic reset,
   hcbs_req_if  req_mon,
   hcbs_rsp_if  rsp_mon,
   output int   mismatch_count,
   output int   verbs_owed
);

   localparam logic [3:0] ST_IDLE       = 4'd0;
   localparam logic [3:0] ST_ROOT_COUNT = 4'd1;
   localparam logic [3:0] ST_GROUP_SCAN = 4'd2;
   localparam logic [3:0] ST_POWER_UP   = 4'd3;
   localparam logic [3:0] ST_NODE_RANGE = 4'd4;
   localparam logic [3:0] ST_WIDGET_CAP = 4'd5;
   localparam logic [3:0] ST_DAC        = 4'd6;
   localparam logic [3:0] ST_PIN_CFG    = 4'd7;
   localparam logic [3:0] ST_PIN        = 4'd8;
   localparam logic [3:0] ST_MIX_CAP    = 4'd9;
   localparam logic [3:0] ST_MIX        = 4'd10;
   localparam logic [3:0] ST_SEL        = 4'd11;

   localparam logic [14:0] CODEC_BITS = 15'((1 << MAX_CODECS) - 1);

   logic [3:0]  phase;
   logic [14:0] codecs_left;
   logic [3:0]  codec_idx;
   logic [7:0]  group_node;
   logic [5:0]  search_left;
   logic [7:0]  cur_node;
   logic [7:0]  last_node;
   logic [4:0]  sub_step;
   logic [4:0]  mix_inputs;
   logic        hp_pin;
   logic [14:0] skipped;

   hcbs_pkg::rsp_item_type verbs_due[$];
   int fail_total = 0;
   int owed = 0;

   assign mismatch_count = fail_total;
   assign verbs_owed     = owed;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (fail_total < 50)
         $display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
      fail_total++;
   endtask

   function automatic void clear_walk();
      phase       = ST_IDLE;
      codecs_left = '0;
      codec_idx   = '0;
      group_node  = '0;
      search_left = '0;
      cur_node    = '0;
      last_node   = '0;
      sub_step    = '0;
      mix_inputs  = '0;
      hp_pin      = 1'b0;
      skipped     = '0;
   endfunction

   function automatic hcbs_pkg::rsp_item_type node_verb(input logic [7:0] node,
                                                        input logic [hcbs_pkg::PAY_W-1:0] pay);
      hcbs_pkg::rsp_item_type v;
      v = '0;
      v.verb_word = {codec_idx, node, pay};
      return v;
   endfunction

   // lowest pending codec address first; none left closes the sequence
   function automatic hcbs_pkg::rsp_item_type open_next_codec();
      hcbs_pkg::rsp_item_type v;
      int c;
      int pick;
      v = '0;
      pick = -1;
      for (c = MAX_CODECS - 1; c >= 0; c--)
         if (codecs_left[c]) pick = c;
      if (pick < 0) begin
         phase            = ST_IDLE;
         codecs_left      = '0;
         v.all_done       = 1'b1;
         v.skipped_codecs = skipped;
      end else begin
         codecs_left[pick] = 1'b0;
         codec_idx         = 4'(pick);
         phase             = ST_ROOT_COUNT;
         v = node_verb(8'd0, hcbs_pkg::VB_GET_NODE_CNT);
      end
      return v;
   endfunction

   function automatic hcbs_pkg::rsp_item_type skip_codec();
      skipped[codec_idx] = 1'b1;
      return open_next_codec();
   endfunction

   function automatic hcbs_pkg::rsp_item_type visit_node();
      if (cur_node > last_node)
         return open_next_codec();
      phase = ST_WIDGET_CAP;
      return node_verb(cur_node, hcbs_pkg::VB_GET_WCAP);
   endfunction

   function automatic hcbs_pkg::rsp_item_type next_node();
      cur_node = cur_node + 8'd1;
      return visit_node();
   endfunction

   function automatic hcbs_pkg::rsp_item_type mixer_unmute();
      return node_verb(cur_node, hcbs_pkg::VB_MIX_UNMUTE | {8'h00, sub_step[3:0], 8'h00});
   endfunction

   // returns 1 when the transaction produces a response
   function automatic bit sequence_step(input hcbs_pkg::req_item_type it,
                                        output hcbs_pkg::rsp_item_type verb);
      logic [31:0] r;
      logic [7:0]  a;
      logic [7:0]  b;
      logic [6:0]  ins;
      logic [hcbs_pkg::PAY_W-1:0] pay;
      bit produced;
      r = it.reply_word;
      verb = '0;
      produced = 1'b1;
      if (it.cmd == hcbs_pkg::CMD_START) begin
         clear_walk();
         codecs_left = it.codec_mask & CODEC_BITS;
         verb = open_next_codec();
      end else begin
         case (phase)
            ST_ROOT_COUNT: begin
               a = r[23:16];
               b = r[7:0];
               if (b == 8'd0 || b > 8'd32) begin
                  verb = skip_codec();
               end else begin
                  search_left = b[5:0];
                  cur_node    = a;
                  phase       = ST_GROUP_SCAN;
                  verb = node_verb(cur_node, hcbs_pkg::VB_GET_FG_TYPE);
               end
            end
            ST_GROUP_SCAN: begin
               if (r[7:0] == 8'd1) begin
                  if (cur_node == 8'd0) begin
                     verb = skip_codec();
                  end else begin
                     group_node = cur_node;
                     phase      = ST_POWER_UP;
                     verb = node_verb(group_node, hcbs_pkg::VB_POWER_D0);
                  end
               end else begin
                  search_left = search_left - 6'd1;
                  if (search_left == 6'd0) begin
                     verb = skip_codec();
                  end else begin
                     cur_node = cur_node + 8'd1;
                     verb = node_verb(cur_node, hcbs_pkg::VB_GET_FG_TYPE);
                  end
               end
            end
            ST_POWER_UP: begin
               phase = ST_NODE_RANGE;
               verb = node_verb(group_node, hcbs_pkg::VB_GET_NODE_CNT);
            end
            ST_NODE_RANGE: begin
               a = r[23:16];
               b = r[7:0];
               // bad child range falls back to nodes 2..11
               if (a < 8'd2 || a > 8'd100 || b == 8'd0 || b > 8'd64) begin
                  a = 8'd2;
                  b = 8'd10;
               end
               cur_node  = a;
               last_node = a + b - 8'd1;
               verb = visit_node();
            end
            ST_WIDGET_CAP: begin
               sub_step = '0;
               case (r[23:20])
                  hcbs_pkg::WT_DAC: begin
                     phase = ST_DAC;
                     verb = node_verb(cur_node, hcbs_pkg::VB_POWER_D0);
                  end
                  hcbs_pkg::WT_PIN: begin
                     phase = ST_PIN_CFG;
                     verb = node_verb(cur_node, hcbs_pkg::VB_GET_PIN_CFG);
                  end
                  hcbs_pkg::WT_MIXER: begin
                     phase = ST_MIX_CAP;
                     verb = node_verb(cur_node, hcbs_pkg::VB_GET_AMP_IN);
                  end
                  hcbs_pkg::WT_SELECTOR: begin
                     phase = ST_SEL;
                     verb = node_verb(cur_node, hcbs_pkg::VB_POWER_D0);
                  end
                  default: verb = next_node();
               endcase
            end
            ST_DAC: begin
               sub_step = sub_step + 5'd1;
               if (sub_step < 5'd5) begin
                  case (sub_step)
                     5'd1:    pay = hcbs_pkg::VB_STREAM_FMT;
                     5'd2:    pay = hcbs_pkg::VB_STREAM_CH;
                     5'd3:    pay = hcbs_pkg::VB_AMP_OUT_UNMUTE;
                     default: pay = hcbs_pkg::VB_AMP_ALL_UNMUTE;
                  endcase
                  verb = node_verb(cur_node, pay);
               end else begin
                  verb = next_node();
               end
            end
            ST_PIN_CFG: begin
               if (r[31:30] == hcbs_pkg::PORT_NONE) begin
                  verb = next_node();
               end else begin
                  hp_pin   = (r[23:20] == hcbs_pkg::DEV_HEADPHONE);
                  phase    = ST_PIN;
                  sub_step = '0;
                  verb = node_verb(cur_node, hcbs_pkg::VB_POWER_D0);
               end
            end
            ST_PIN: begin
               sub_step = sub_step + 5'd1;
               if (sub_step < 5'd6) begin
                  case (sub_step)
                     5'd1:    pay = hcbs_pkg::VB_CONN_SEL0;
                     5'd2:    pay = hcbs_pkg::VB_PIN_CTL | hcbs_pkg::PIN_OUT_EN |
                                    (hp_pin ? hcbs_pkg::PIN_HP_EN : '0);
                     5'd3:    pay = hcbs_pkg::VB_EAPD;
                     5'd4:    pay = hcbs_pkg::VB_AMP_OUT_UNMUTE;
                     default: pay = hcbs_pkg::VB_AMP_IN_UNMUTE;
                  endcase
                  verb = node_verb(cur_node, pay);
               end else begin
                  verb = next_node();
               end
            end
            ST_MIX_CAP: begin
               ins = r[22:16];
               if (ins > 7'(MAX_MIXER_INPUTS)) ins = 7'(MAX_MIXER_INPUTS);
               if (ins == 7'd0) begin
                  verb = next_node();
               end else begin
                  mix_inputs = ins[4:0];
                  sub_step   = '0;
                  phase      = ST_MIX;
                  verb = mixer_unmute();
               end
            end
            ST_MIX: begin
               sub_step = sub_step + 5'd1;
               if (sub_step < mix_inputs) verb = mixer_unmute();
               else verb = next_node();
            end
            ST_SEL: begin
               sub_step = sub_step + 5'd1;
               if (sub_step < 5'd2) verb = node_verb(cur_node, hcbs_pkg::VB_CONN_SEL0);
               else verb = next_node();
            end
            default: produced = 1'b0;   // reply while idle
         endcase
      end
      return produced;
   endfunction

   always @(posedge clock) begin : watch
      hcbs_pkg::rsp_item_type got;
      hcbs_pkg::rsp_item_type want;
      hcbs_pkg::rsp_item_type next_verb;
      hcbs_pkg::req_item_type taken;
      if (reset) begin
         clear_walk();
         verbs_due.delete();
         owed <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.verb_word      = rsp_mon.verb_word;
            got.all_done       = rsp_mon.all_done;
            got.skipped_codecs = rsp_mon.skipped_codecs;
            if (verbs_due.size() == 0) begin
               report_mismatch("response with nothing pending", got.verb_word, '0);
            end else begin
               want = verbs_due.pop_front();
               if (got.verb_word != want.verb_word)
                  report_mismatch("verb_word", got.verb_word, want.verb_word);
               if (got.all_done != want.all_done)
                  report_mismatch("all_done", 32'(got.all_done), 32'(want.all_done));
               if (got.skipped_codecs != want.skipped_codecs)
                  report_mismatch("skipped_codecs", 32'(got.skipped_codecs),
                                  32'(want.skipped_codecs));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            taken.cmd        = req_mon.cmd;
            taken.codec_mask = req_mon.codec_mask;
            taken.reply_word = req_mon.reply_word;
            if (sequence_step(taken, next_verb))
               verbs_due.push_back(next_verb);
         end
         owed <= verbs_due.size();
      end
   end

endmodule

/* tb/tb_hda_codec_bringup_sequencer.sv */
`timescale 1ns / 1ps

module tb_hda_codec_bringup_sequencer;

   localparam int N_ITEMS     = 1650;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 80;

   logic clock;
   logic reset;

   hcbs_req_if req_bus();
   hcbs_rsp_if rsp_bus();

   int fail_count;
   int verbs_owed;

   hda_codec_bringup_sequencer u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   hcbs_seq_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .mismatch_count (fail_count),
      .verbs_owed     (verbs_owed)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   int cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses still owed", cycle_count, verbs_owed);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // response side: random back-pressure, plus one long hold on request
   logic [31:0] last_verb;
   logic        last_done;
   int          rsp_count;
   int          done_count;
   int          hold_asks;

   initial begin : rsp_sink
      int stall;
      int taken;
      int holds_served;
      bit rsp_fast;
      taken = 0;
      holds_served = 0;
      rsp_fast = 1'b0;
      rsp_bus.ready = 1'b0;
      last_verb = '0;
      last_done = 1'b1;
      rsp_count = 0;
      done_count = 0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (holds_served != hold_asks) begin
            holds_served++;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (taken % 50 == 0) rsp_fast = ($urandom_range(0, 3) == 0);
         stall = rsp_fast ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         taken++;
         last_verb <= rsp_bus.verb_word;
         last_done <= rsp_bus.all_done;
         rsp_count <= rsp_count + 1;
         if (rsp_bus.all_done) done_count <= done_count + 1;
      end
   end

   // request side
   bit req_fast;
   bit seq_live;

   function automatic hcbs_pkg::req_item_type start_item(input logic [14:0] mask);
      hcbs_pkg::req_item_type it;
      it.cmd        = hcbs_pkg::CMD_START;
      it.codec_mask = mask;
      it.reply_word = $urandom();
      return it;
   endfunction

   function automatic hcbs_pkg::req_item_type reply_item(input logic [31:0] word);
      hcbs_pkg::req_item_type it;
      it.cmd        = hcbs_pkg::CMD_REPLY;
      it.codec_mask = 15'($urandom());
      it.reply_word = word;
      return it;
   endfunction

   function automatic logic [14:0] random_mask();
      logic [14:0] m;
      int k;
      m = '0;
      k = $urandom_range(0, 29);
      if (k == 1 || k == 2 || k == 3) m = 15'($urandom());
      else if (k > 3)
         repeat ($urandom_range(1, 3)) m[$urandom_range(0, 14)] = 1'b1;
      return m;
   endfunction

   // plausible codec answer to the verb just issued, with the odd bad value
   function automatic logic [31:0] codec_reply(input logic [31:0] verb);
      logic [31:0] r;
      logic [7:0]  node;
      logic [19:0] pay;
      int k;
      r = $urandom();
      node = verb[27:20];
      pay = verb[19:0];
      if ($urandom_range(0, 39) == 0) return '0;   // link timeout
      case (pay)
         hcbs_pkg::VB_GET_NODE_CNT: begin
            k = $urandom_range(0, 99);
            if (node == 8'd0) begin
               if (k < 85) begin
                  r[23:16] = 8'($urandom_range(0, 3));
                  r[7:0]   = 8'($urandom_range(1, 4));
               end else if (k < 90) begin
                  r[7:0] = (k < 88) ? 8'd32 : 8'd33;
               end else if (k < 93) begin
                  r[7:0] = 8'd0;
               end
            end else if (k < 70) begin
               r[23:16] = 8'($urandom_range(2, 12));
               r[7:0]   = 8'($urandom_range(1, 5));
            end else if (k < 98) begin
               case ($urandom_range(0, 3))
                  0:       r[23:16] = 8'($urandom_range(0, 1));
                  1:       r[23:16] = 8'($urandom_range(101, 255));
                  2:       r[7:0]   = 8'd0;
                  default: r[7:0]   = 8'($urandom_range(65, 255));
               endcase
            end else begin
               r[23:16] = 8'd100;
               r[7:0]   = (k == 98) ? 8'd1 : 8'd64;
            end
         end
         hcbs_pkg::VB_GET_FG_TYPE:
            if ($urandom_range(0, 2) == 0) r[7:0] = 8'd1;
         hcbs_pkg::VB_GET_WCAP:
            case ($urandom_range(0, 5))
               0: r[23:20] = hcbs_pkg::WT_DAC;
               1: r[23:20] = hcbs_pkg::WT_PIN;
               2: r[23:20] = hcbs_pkg::WT_MIXER;
               3: r[23:20] = hcbs_pkg::WT_SELECTOR;
               default: ;
            endcase
         hcbs_pkg::VB_GET_PIN_CFG:
            if ($urandom_range(0, 1) == 0) r[23:20] = hcbs_pkg::DEV_HEADPHONE;
         hcbs_pkg::VB_GET_AMP_IN:
            if ($urandom_range(0, 3) != 0) r[22:16] = 7'($urandom_range(0, 10));
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_req(input hcbs_pkg::req_item_type it, input bit keep_valid,
                           input bit no_gap);
      int gap;
      gap = (no_gap || req_fast) ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.cmd        <= it.cmd;
      req_bus.codec_mask <= it.codec_mask;
      req_bus.reply_word <= it.reply_word;
      do @(posedge clock); while (!req_bus.ready);
      if (!keep_valid) req_bus.valid <= 1'b0;
   endtask

   task automatic settle();
      @(posedge clock);
      while (verbs_owed != 0) @(posedge clock);
      seq_live = !last_done;
   endtask

   task automatic issue(input hcbs_pkg::req_item_type it);
      send_req(it, 1'b0, 1'b0);
      settle();
   endtask

   initial begin : stimulus
      int sent;
      int starts;
      int k;
      bit burst_done;
      hcbs_pkg::req_item_type it;
      sent = 0;
      starts = 0;
      burst_done = 1'b0;
      req_fast = 1'b0;
      seq_live = 1'b0;
      hold_asks = 0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.cmd = hcbs_pkg::CMD_START;
      req_bus.codec_mask = '0;
      req_bus.reply_word = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty mask, idle reply, bad root counts, group at node zero,
      // restart while busy, group search running out
      issue(start_item(15'h0000));
      issue(reply_item(32'hFFFF_FFFF));
      issue(start_item(15'h7FFF));
      issue(reply_item(32'h0000_0000));
      issue(reply_item(32'hFFFF_FFFF));
      issue(reply_item(32'h0000_0021));
      issue(reply_item(32'h0000_0020));
      issue(reply_item(32'h0000_0001));
      issue(start_item(15'h0000));
      issue(start_item(15'h4000));
      issue(reply_item(32'h0001_0002));
      issue(reply_item(32'h0000_0000));
      issue(reply_item(32'h0000_0000));
      sent = 13;
      starts = 4;

      while (sent < N_ITEMS) begin
         if (sent % 40 == 0) req_fast = ($urandom_range(0, 3) == 0);
         if (!burst_done && sent >= 300) begin
            // stall the response side and keep pushing until the input backs up
            burst_done = 1'b1;
            hold_asks <= hold_asks + 1;
            send_req(start_item(15'h7FFF), 1'b1, 1'b1);
            for (int i = 0; i < 8; i++)
               send_req(reply_item($urandom()), i < 7, 1'b1);
            settle();
            sent += 9;
            starts++;
         end else if (!seq_live) begin
            if ($urandom_range(0, 9) == 0) begin
               issue(reply_item($urandom()));
            end else begin
               issue(start_item(random_mask()));
               starts++;
            end
            sent++;
         end else begin
            k = $urandom_range(0, 99);
            if (k < 2) begin
               it = start_item(random_mask());
               starts++;
            end else if (k < 10) begin
               it = reply_item($urandom());
            end else begin
               it = reply_item(codec_reply(last_verb));
            end
            issue(it);
            sent++;
         end
      end

      settle();
      repeat (8) @(posedge clock);
      $display("Drove %0d request transactions (%0d sequence starts), checked %0d responses",
               sent, starts, rsp_count);
      $display("Finished bring-up sequences: %0d, including one input back-pressure burst",
               done_count);
      if (fail_count == 0 && verbs_owed == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/hcbs_pkg.sv
rtl/hcbs_req_if.sv
rtl/hcbs_rsp_if.sv
rtl/hcbs_seq_core.sv
rtl/hcbs_rsp_buf.sv
rtl/hda_codec_bringup_sequencer.sv
tb/hcbs_seq_checker.sv
tb/tb_hda_codec_bringup_sequencer.sv
